>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge.
`define GPTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define GPTT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GPTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/gptt_pkg.sv
// ----------------------------------------------------------------------------
// gptt_pkg
// Types and constants shared by the page table translation block.
// ----------------------------------------------------------------------------
`default_nettype none

package gptt_pkg;

    localparam int ADDR_W              = 32;
    localparam int PAGE_SHIFT          = 12;
    localparam int PAGE_BYTES          = 4096;
    localparam int OFFSET_W            = PAGE_SHIFT;
    localparam int PAGE_W              = ADDR_W - PAGE_SHIFT;
    localparam int FRAME_W             = ADDR_W - PAGE_SHIFT;
    localparam int CNT_W               = 21;
    localparam int CFG_W               = 18;
    localparam int PAGES_W             = 18;
    localparam int ENTRY_W             = FRAME_W + 1;
    localparam int CFG_RESET           = 131072;
    localparam int DEFAULT_MAX_ENTRIES = 131072;
    localparam int QUEUE_DEPTH         = 2;
    localparam int QPTR_W              = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_TRANSLATE = 2'd0;
    localparam logic [1:0] REQ_MAP       = 2'd1;
    localparam logic [1:0] REQ_MAP_CACHE = 2'd2;
    localparam logic [1:0] REQ_UNMAP     = 2'd3;

    typedef enum logic [1:0] {
        KIND_MISS,
        KIND_TRANSLATE,
        KIND_MAP,
        KIND_UNMAP
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [PAGE_W-1:0]    page;
        logic [OFFSET_W-1:0]  offset;
        logic [FRAME_W-1:0]   frame;
        logic [CNT_W-1:0]     pages;
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/core/gptt_if.sv
// ----------------------------------------------------------------------------
// gptt interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gptt_req_if;
    import gptt_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [ADDR_W-1:0] length_bytes;

    modport source (output valid, req_type, virt_addr, phys_addr, length_bytes,
                    input ready);
    modport sink   (input valid, req_type, virt_addr, phys_addr, length_bytes,
                    output ready);
endinterface

interface gptt_rsp_if;
    import gptt_pkg::*;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  translated_addr;
    logic               hit;
    logic [PAGES_W-1:0] pages_written;

    modport source (output valid, translated_addr, hit, pages_written, input ready);
    modport sink   (input valid, translated_addr, hit, pages_written, output ready);
endinterface

interface gptt_cfg_if;
    import gptt_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] table_entries;

    modport source (output valid, table_entries, input ready);
    modport sink   (input valid, table_entries, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gptt_front.sv
// ----------------------------------------------------------------------------
// gptt_front
// Accepts requests, holds the table size register and classifies each request
// into a command for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module gptt_front #(
    parameter int MAX_ENTRIES = gptt_pkg::DEFAULT_MAX_ENTRIES,
    parameter int LIM_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    gptt_req_if.sink             i_req,
    gptt_cfg_if.sink             i_cfg,
    input  wire logic            i_clear_busy,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output gptt_pkg::t_cmd       o_cmd,
    output logic [LIM_W-1:0]     o_limit
);
    import gptt_pkg::*;

    localparam int RESET_LIM = (CFG_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CFG_RESET;

    logic [LIM_W-1:0]    r_limit;
    logic [LIM_W-1:0]    n_limit;
    logic [ADDR_W:0]     len_sum;
    logic [CNT_W-1:0]    walk_pages;
    logic [PAGE_W-1:0]   page;
    logic                in_range;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (CNT_W'(i_cfg.table_entries) > CNT_W'(MAX_ENTRIES)) begin
            n_limit = LIM_W'(MAX_ENTRIES);
        end else begin
            n_limit = LIM_W'(i_cfg.table_entries);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(RESET_LIM);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_limit <= n_limit;
        end
    end

    assign o_limit     = r_limit;
    assign i_req.ready = !i_q_full && !i_clear_busy;
    assign o_push      = i_req.valid && i_req.ready;

    assign page     = i_req.virt_addr[ADDR_W-1:PAGE_SHIFT];
    assign in_range = CNT_W'(page) < CNT_W'(r_limit);
    assign len_sum  = {1'b0, i_req.length_bytes} + (ADDR_W + 1)'(PAGE_BYTES - 1);

    always_comb begin
        if (len_sum[ADDR_W:PAGE_SHIFT] == '0) begin
            walk_pages = CNT_W'(1);
        end else begin
            walk_pages = len_sum[ADDR_W:PAGE_SHIFT];
        end
    end

    always_comb begin
        o_cmd.page   = page;
        o_cmd.offset = i_req.virt_addr[OFFSET_W-1:0];
        o_cmd.frame  = '0;
        o_cmd.pages  = '0;
        o_cmd.kind   = KIND_MISS;
        unique case (i_req.req_type) inside
            REQ_TRANSLATE: begin
                o_cmd.kind = in_range ? KIND_TRANSLATE : KIND_MISS;
            end
            REQ_MAP, REQ_MAP_CACHE: begin
                o_cmd.kind  = KIND_MAP;
                o_cmd.frame = i_req.phys_addr[ADDR_W-1:PAGE_SHIFT];
                o_cmd.pages = (page == '0) ? '0 : walk_pages;
            end
            REQ_UNMAP: begin
                o_cmd.kind  = KIND_UNMAP;
                o_cmd.pages = walk_pages;
            end
            default: begin
                o_cmd.kind = KIND_MISS;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/gptt_cmd_queue.sv
// ----------------------------------------------------------------------------
// gptt_cmd_queue
// Short command queue between the request front end and the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module gptt_cmd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire gptt_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output gptt_pkg::t_cmd       o_cmd
);
    import gptt_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`include "assert_macros.svh"

    `GPTT_ASSERT_IMPL(a_push_not_full, i_push, !o_full || i_pop, "push into a full queue")
    `GPTT_ASSERT_IMPL(a_pop_not_empty, i_pop, o_valid, "pop from an empty queue")

endmodule

`default_nettype wire

>>> rtl/core/gptt_back.sv
// ----------------------------------------------------------------------------
// gptt_back
// Owns the page table memory: clears it after reset, performs lookups and
// map/unmap walks one entry per cycle, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gptt_back #(
    parameter int MAX_ENTRIES = gptt_pkg::DEFAULT_MAX_ENTRIES,
    parameter int LIM_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [LIM_W-1:0] i_limit,
    input  wire logic            i_q_valid,
    input  wire gptt_pkg::t_cmd  i_q_cmd,
    output logic                 o_pop,
    output logic                 o_clear_busy,
    gptt_rsp_if.source           o_rsp
);
    import gptt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_EMIT
    } t_state;

    logic [ENTRY_W-1:0]  r_table [MAX_ENTRIES];
    logic [ENTRY_W-1:0]  r_rd_data;

    t_state              r_state;
    logic [IDX_W-1:0]    r_clr_idx;
    logic [CNT_W-1:0]    r_page;
    logic [FRAME_W-1:0]  r_frame;
    logic                r_valid_bit;
    logic [CNT_W-1:0]    r_left;
    logic [CNT_W-1:0]    r_count;
    logic [OFFSET_W-1:0] r_offset;
    logic [ADDR_W-1:0]   r_res_addr;
    logic                r_res_hit;
    logic [PAGES_W-1:0]  r_res_pages;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_hit;
    logic [PAGES_W-1:0]  r_out_pages;

    logic                out_free;
    logic                walk_go;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_widx;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic                res_now;
    logic [ADDR_W-1:0]   res_addr;
    logic                res_hit;
    logic [PAGES_W-1:0]  res_pages;

    assign out_free     = !r_out_valid || o_rsp.ready;
    assign walk_go      = (r_left != '0) && (r_page < CNT_W'(i_limit));
    assign o_pop        = (r_state == ST_IDLE) && i_q_valid;
    assign o_clear_busy = r_state == ST_CLEAR;
    assign mem_re       = o_pop && (i_q_cmd.kind == KIND_TRANSLATE);

    always_comb begin
        mem_we    = 1'b0;
        mem_widx  = r_page[IDX_W-1:0];
        mem_wdata = {r_frame, r_valid_bit};
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_widx  = r_clr_idx;
            mem_wdata = '0;
        end else if (r_state == ST_WALK) begin
            mem_we = walk_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_widx] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_table[i_q_cmd.page[IDX_W-1:0]];
        end
    end

    always_comb begin
        res_now   = 1'b0;
        res_addr  = '0;
        res_hit   = 1'b0;
        res_pages = '0;
        case (r_state)
            ST_IDLE: begin
                res_now = i_q_valid && (i_q_cmd.kind == KIND_MISS);
            end
            ST_READ: begin
                res_now = 1'b1;
                res_hit = r_rd_data[0];
                if (r_rd_data[0]) begin
                    res_addr = {r_rd_data[ENTRY_W-1:1], r_offset};
                end
            end
            ST_WALK: begin
                res_now   = !walk_go;
                res_pages = r_count[PAGES_W-1:0];
            end
            ST_EMIT: begin
                res_now   = 1'b1;
                res_addr  = r_res_addr;
                res_hit   = r_res_hit;
                res_pages = r_res_pages;
            end
            default: begin
                res_now = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (res_now && out_free) begin
                r_out_valid <= 1'b1;
                r_out_addr  <= res_addr;
                r_out_hit   <= res_hit;
                r_out_pages <= res_pages;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (res_now) begin
                r_res_addr  <= res_addr;
                r_res_hit   <= res_hit;
                r_res_pages <= res_pages;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(MAX_ENTRIES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        unique case (i_q_cmd.kind)
                            KIND_MISS: begin
                                r_state <= out_free ? ST_IDLE : ST_EMIT;
                            end
                            KIND_TRANSLATE: begin
                                r_offset <= i_q_cmd.offset;
                                r_state  <= ST_READ;
                            end
                            KIND_MAP, KIND_UNMAP: begin
                                r_page      <= CNT_W'(i_q_cmd.page);
                                r_frame     <= i_q_cmd.frame;
                                r_valid_bit <= i_q_cmd.kind == KIND_MAP;
                                r_left      <= i_q_cmd.pages;
                                r_count     <= '0;
                                r_state     <= ST_WALK;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_state <= out_free ? ST_IDLE : ST_EMIT;
                end
                ST_WALK: begin
                    if (walk_go) begin
                        r_page  <= r_page + 1'b1;
                        r_frame <= r_frame + 1'b1;
                        r_left  <= r_left - 1'b1;
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_state <= out_free ? ST_IDLE : ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.translated_addr = r_out_addr;
    assign o_rsp.hit             = r_out_hit;
    assign o_rsp.pages_written   = r_out_pages;

`include "assert_macros.svh"

    `GPTT_ASSERT_IMPL(a_queue_empty_in_clear, r_state == ST_CLEAR, !i_q_valid, "command queued during table clear")
    `GPTT_ASSERT_NEXT(a_walk_conserves, r_state == ST_WALK, (r_state != ST_WALK) || ((r_count + r_left) == $past(r_count + r_left)), "walk count and remaining pages out of step")
    `GPTT_ASSERT_IMPL(a_read_no_pop, r_state == ST_READ, !o_pop, "command popped while a lookup is pending")

endmodule

`default_nettype wire

>>> rtl/core/graphics_page_table_map_translate.sv
// ----------------------------------------------------------------------------
// graphics_page_table_map_translate
// Aperture page table with 4 KiB pages: translate, map, cacheable map, unmap.
// ----------------------------------------------------------------------------
// Requests enter on i_req (valid/ready) and each yields exactly one result on
// o_rsp (valid/ready), in request order. The table size is set through i_cfg,
// which is always ready. The user must see that it is written only while the
// block is idle; the block itself does not enforce this. After reset the table
// memory is cleared one entry per cycle, all MAX_ENTRIES entries (131072 by
// default), and i_req.ready stays low until the clear is done.
// A request is classified on transfer and queued in a two-entry command queue;
// the execution side pops it once in its idle state. A translate passes through
// the queue, the registered read of the table memory and the output register;
// the execution side pops no further command while its lookup is pending.
// A map or unmap walk writes one entry per cycle through the single memory
// write port.
// Results sit in an output register; while the receiver stalls, the command
// queue keeps taking requests until it is full, then i_req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module graphics_page_table_map_translate #(
    parameter int MAX_ENTRIES = gptt_pkg::DEFAULT_MAX_ENTRIES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gptt_req_if.sink     i_req,
    gptt_cfg_if.sink     i_cfg,
    gptt_rsp_if.source   o_rsp
);
    import gptt_pkg::*;

    localparam int LIM_W = $clog2(MAX_ENTRIES + 1);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic             clear_busy;
    logic [LIM_W-1:0] limit;
    t_cmd             cmd_in;
    t_cmd             cmd_out;

    gptt_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .LIM_W       (LIM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg        (i_cfg),
        .i_clear_busy (clear_busy),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (cmd_in),
        .o_limit      (limit)
    );

    gptt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (cmd_out)
    );

    gptt_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .LIM_W       (LIM_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limit      (limit),
        .i_q_valid    (q_valid),
        .i_q_cmd      (cmd_out),
        .o_pop        (pop),
        .o_clear_busy (clear_busy),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire

>>> test/graphics_page_table_map_translate_shadow.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page table shadow and result checker
// Watches the request, configuration and result channels of the aperture page
// table. Every accepted request is applied to a shadow copy of the table and
// the result it should give is queued; every accepted result is compared
// field by field with the oldest queued one. The failure count and the number
// of results still due are handed to the test top.
// ----------------------------------------------------------------------------
module graphics_page_table_map_translate_shadow #(
    parameter int MAX_ENTRIES = gptt_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gptt_req_if  i_req,
    gptt_cfg_if  i_cfg,
    gptt_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);
    import gptt_pkg::*;

    localparam logic [ADDR_W-1:0] ENTRY_VALID  = 32'h0000_0001;
    localparam logic [ADDR_W-1:0] ENTRY_CACHED = 32'h0000_0007;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic               hit;
        logic [PAGES_W-1:0] pages;
    } t_xlate_outcome;

    logic [ADDR_W-1:0] shadow_tbl [MAX_ENTRIES];
    logic [CFG_W-1:0]  tbl_size;
    t_xlate_outcome    due_responses [$];
    int                fail_count;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    function automatic t_xlate_outcome apply_request(input logic [1:0] kind,
                                                     input logic [ADDR_W-1:0] va,
                                                     input logic [ADDR_W-1:0] pa,
                                                     input logic [ADDR_W-1:0] len);
        t_xlate_outcome    res;
        logic [PAGE_W-1:0] page;
        logic [ADDR_W-1:0] frame;
        logic [ADDR_W-1:0] flags;
        logic [ADDR_W:0]   span;
        logic [CNT_W-1:0]  left;
        int unsigned       lim;
        int unsigned       idx;
        res   = '0;
        page  = va[ADDR_W-1:PAGE_SHIFT];
        lim   = (tbl_size > MAX_ENTRIES) ? MAX_ENTRIES : tbl_size;
        if (kind == REQ_TRANSLATE) begin
            if (page < lim && shadow_tbl[page][0]) begin
                res.addr = {shadow_tbl[page][ADDR_W-1:PAGE_SHIFT], va[PAGE_SHIFT-1:0]};
                res.hit  = 1'b1;
            end
        end else if (kind == REQ_UNMAP || page != '0) begin
            span  = {1'b0, len} + (ADDR_W+1)'(PAGE_BYTES - 1);
            left  = CNT_W'(span >> PAGE_SHIFT);
            if (left == '0) begin
                left = CNT_W'(1);
            end
            frame = pa;
            flags = (kind == REQ_MAP) ? ENTRY_VALID : ENTRY_CACHED;
            idx   = page;
            while (left != '0 && idx < lim) begin
                if (kind == REQ_UNMAP) begin
                    shadow_tbl[idx] = '0;
                end else begin
                    shadow_tbl[idx] = {frame[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} | flags;
                end
                frame = frame + PAGE_BYTES;
                idx++;
                left--;
                res.pages++;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_xlate_outcome want;
        if (!i_rst_n) begin
            foreach (shadow_tbl[i]) begin
                shadow_tbl[i] = '0;
            end
            tbl_size   = CFG_W'(CFG_RESET);
            fail_count = 0;
            due_responses.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_responses.size() == 0) begin
                    report($sformatf("result transfer with none due: addr 0x%08h hit %0b pages %0d",
                                     i_rsp.translated_addr, i_rsp.hit, i_rsp.pages_written));
                end else begin
                    want = due_responses.pop_front();
                    if (i_rsp.translated_addr !== want.addr) begin
                        report($sformatf("translated_addr 0x%08h, expected 0x%08h",
                                         i_rsp.translated_addr, want.addr));
                    end
                    if (i_rsp.hit !== want.hit) begin
                        report($sformatf("hit %0b, expected %0b", i_rsp.hit, want.hit));
                    end
                    if (i_rsp.pages_written !== want.pages) begin
                        report($sformatf("pages_written %0d, expected %0d",
                                         i_rsp.pages_written, want.pages));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                tbl_size = i_cfg.table_entries;
            end
            if (i_req.valid && i_req.ready) begin
                due_responses.push_back(apply_request(i_req.req_type, i_req.virt_addr,
                                                      i_req.phys_addr, i_req.length_bytes));
            end
        end
        o_outstanding <= due_responses.size();
        o_fail_count  <= fail_count;
    end

endmodule

>>> test/graphics_page_table_map_translate_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aperture page table testbench
// Drives translate, map, cacheable map and unmap requests through the block in
// bursts with random gaps while the result side stalls on a rotating pattern
// and once in a while holds off for a long stretch. A directed sequence covers
// the boundary cases, then random requests run under a series of table sizes.
// The shadow module does all prediction and checking.
// ----------------------------------------------------------------------------
module graphics_page_table_map_translate_test;
    import gptt_pkg::*;

    localparam int MAX_ENTRIES     = DEFAULT_MAX_ENTRIES;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gptt_req_if req_ch ();
    gptt_cfg_if cfg_ch ();
    gptt_rsp_if rsp_ch ();

    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    int          items_issued = 0;
    int          burst_left = 0;
    int unsigned cur_limit = MAX_ENTRIES;
    logic        hold_off;
    logic [15:0] stall_pat;
    logic [5:0]  pat_age;

    graphics_page_table_map_translate #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    graphics_page_table_map_translate_shadow #(.MAX_ENTRIES(MAX_ENTRIES)) shadow (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_cfg         (cfg_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_pat    <= '1;
            pat_age      <= '0;
        end else begin
            rsp_ch.ready <= stall_pat[0] && !hold_off;
            if (pat_age == '1) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat <= '1;
                    1:       stall_pat <= 16'($urandom);
                    2:       stall_pat <= 16'($urandom | $urandom);
                    default: stall_pat <= 16'($urandom & $urandom);
                endcase
            end else begin
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
            end
            pat_age <= pat_age + 1'b1;
        end
    end

    // The result side holds off long enough for the request path to back up.
    initial begin
        int hold_points [2];
        hold_points = '{400, 1300};
        hold_off = 1'b0;
        foreach (hold_points[i]) begin
            wait (items_issued >= hold_points[i]);
            @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] va,
                                input logic [ADDR_W-1:0] pa, input logic [ADDR_W-1:0] len);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.virt_addr    <= va;
        req_ch.phys_addr    <= pa;
        req_ch.length_bytes <= len;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        burst_left--;
        items_issued++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [CFG_W-1:0] value);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.table_entries <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_limit = (value > MAX_ENTRIES) ? MAX_ENTRIES : value;
    endtask

    task automatic send_random_request();
        logic [1:0]        kind;
        logic [ADDR_W-1:0] pa;
        logic [ADDR_W-1:0] len;
        int unsigned       page;
        int unsigned       headroom;
        int unsigned       window;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = REQ_TRANSLATE;
            4, 5:       kind = REQ_MAP;
            6, 7:       kind = REQ_MAP_CACHE;
            default:    kind = REQ_UNMAP;
        endcase
        window = (cur_limit < 48) ? cur_limit + 2 : 48;
        case ($urandom_range(0, 19))
            0:       page = $urandom & 32'h000f_ffff;
            1, 2:    page = (cur_limit + $urandom_range(0, 8) > 4) ?
                            cur_limit + $urandom_range(0, 8) - 4 : 0;
            default: page = $urandom_range(0, window);
        endcase
        page     = page & 32'h000f_ffff;
        headroom = (cur_limit > page) ? cur_limit - page : 0;
        pa       = $urandom;
        if (headroom <= 512 && $urandom_range(0, 3) == 0) begin
            len = $urandom;
        end else if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(0, 8191);
        end else begin
            len = $urandom_range(0, 12 * PAGE_BYTES);
        end
        send_request(kind, {page[PAGE_W-1:0], 12'($urandom)}, pa, len);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_size;
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_TRANSLATE;
        req_ch.virt_addr     <= '0;
        req_ch.phys_addr     <= '0;
        req_ch.length_bytes  <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.table_entries <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Boundary cases under the reset table size.
        send_request(REQ_TRANSLATE, 32'h0000_0000, 32'h0, 32'h0);
        send_request(REQ_MAP,       32'h0000_0abc, 32'h1234_5000, 32'h0000_3000);
        send_request(REQ_MAP,       32'h0000_1000, 32'habcd_e123, 32'h0000_0000);
        send_request(REQ_MAP_CACHE, 32'h0000_2fff, 32'h0000_1000, 32'h0000_1001);
        send_request(REQ_TRANSLATE, 32'h0000_1fff, 32'h0, 32'h0);
        send_request(REQ_TRANSLATE, 32'h0000_3000, 32'h0, 32'h0);
        send_request(REQ_MAP,       32'h0000_a000, 32'hffff_ffff, 32'h0000_2000);
        send_request(REQ_TRANSLATE, 32'h0000_a800, 32'h0, 32'h0);
        send_request(REQ_TRANSLATE, 32'h0000_b123, 32'h0, 32'h0);
        send_request(REQ_UNMAP,     32'h0000_2000, 32'h0, 32'h0000_0001);
        send_request(REQ_TRANSLATE, 32'h0000_2000, 32'h0, 32'h0);
        send_request(REQ_TRANSLATE, 32'hffff_ffff, 32'h0, 32'h0);
        send_request(REQ_MAP_CACHE, 32'h1fff_f000, 32'h0765_4321, 32'h0000_2000);
        send_request(REQ_TRANSLATE, 32'h1fff_f555, 32'h0, 32'h0);
        send_request(REQ_UNMAP,     32'hffff_f000, 32'h0, 32'hffff_ffff);
        send_request(REQ_MAP,       32'h2000_0000, 32'h5555_5000, 32'h0000_1000);
        send_request(REQ_UNMAP,     32'h0000_0000, 32'h0, 32'hffff_ffff);
        send_request(REQ_TRANSLATE, 32'h0000_1fff, 32'h0, 32'h0);
        wait_drained();

        // A small table stops long walks at its end.
        write_table_size(18'd16);
        send_request(REQ_MAP,       32'h0000_1000, 32'h5555_5000, 32'hffff_ffff);
        send_request(REQ_TRANSLATE, 32'h0000_f00f, 32'h0, 32'h0);
        send_request(REQ_TRANSLATE, 32'h0001_0000, 32'h0, 32'h0);
        send_request(REQ_MAP_CACHE, 32'h0001_0000, 32'h0, 32'h0);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       phase_size = 18'h3ffff;
                1:       phase_size = 18'd0;
                2:       phase_size = 18'd300;
                3:       phase_size = 18'd1;
                4:       phase_size = CFG_W'($urandom_range(2, 2048));
                5:       phase_size = 18'd131071;
                default: phase_size = 18'd131072;
            endcase
            write_table_size(phase_size);
            repeat (ITEMS_PER_PHASE) send_random_request();
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
